>>> rtl/mtc_qf_pkg.sv
// Shared types and constants for the MTC quarter-frame generator.
package mtc_qf_pkg;

	localparam int unsigned POS_W = 31;

	localparam logic [7:0] QF_STATUS   = 8'hF1;
	localparam logic [3:0] QF_NIBBLE   = 4'hF;
	localparam logic [3:0] QF_RATE_30  = 4'b0110;

	// piece numbers of the quarter-frame sequence
	localparam logic [2:0] PC_FRAME_LO = 3'd0;
	localparam logic [2:0] PC_FRAME_HI = 3'd1;
	localparam logic [2:0] PC_SEC_LO   = 3'd2;
	localparam logic [2:0] PC_SEC_HI   = 3'd3;
	localparam logic [2:0] PC_MIN_LO   = 3'd4;
	localparam logic [2:0] PC_MIN_HI   = 3'd5;
	localparam logic [2:0] PC_HOUR_LO  = 3'd6;
	localparam logic [2:0] PC_HOUR_HI  = 3'd7;

	localparam logic [4:0] FPS         = 5'd30;
	localparam logic [5:0] SIXTY       = 6'd60;
	localparam logic [4:0] HOUR_WRAP   = 5'd31;

	// reciprocals: q = (n * M) >> K, exact over the range of n at each step
	localparam logic [31:0] RCP_FPS    = 32'd2290649225; // n < 2^31, K = 36
	localparam logic [27:0] RCP_SEC    = 28'd143165577;  // n < 2^27, K = 33
	localparam logic [21:0] RCP_MIN    = 22'd2236963;    // n < 2^21, K = 27
	localparam logic [15:0] RCP_HOUR   = 16'd33826;      // n < 2^15, K = 20

	typedef struct packed {
		logic [4:0] frames;
		logic [5:0] seconds;
		logic [5:0] minutes;
		logic [4:0] hours;
	} mtc_time_t;

endpackage

>>> rtl/mtc_pos_if.sv
// Channel carrying one poll tick with the player's frame position.
interface mtc_pos_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] position;

	modport source (output valid, output position, input ready);
	modport sink   (input valid, input position, output ready);
endinterface

>>> rtl/mtc_qf_if.sv
// Channel carrying one MIDI quarter-frame message.
interface mtc_qf_if;
	logic       valid;
	logic       ready;
	logic [7:0] status_byte;
	logic [6:0] data_byte;
	logic       last_piece;

	modport source (output valid, output status_byte, output data_byte, output last_piece,
		input ready);
	modport sink   (input valid, input status_byte, input data_byte, input last_piece,
		output ready);
endinterface

>>> rtl/mtc_qf_track.sv
// Play-state tracker: clamps the tick position and decides whether it is sent on.
module mtc_qf_track (
	input  logic                           clk,
	input  logic                           arst_n,
	mtc_pos_if.sink                        tick,
	output logic                           pos_valid,
	output logic [mtc_qf_pkg::POS_W-1:0]   pos,
	input  logic                           pos_ready
);
	import mtc_qf_pkg::*;

	logic [POS_W-1:0] last_q;
	logic             seen_q;
	logic             playing_q;
	logic [POS_W-1:0] pos_s1;
	logic             valid_s1;
	logic [POS_W-1:0] clamped;
	logic             same;
	logic             play_next;
	logic             accept;

	// negative positions count as zero
	assign clamped   = tick.position[31] ? '0 : tick.position[POS_W-1:0];
	assign same      = (clamped == last_q);
	assign play_next = same ? (playing_q & ~seen_q) : 1'b1;

	assign tick.ready = ~valid_s1 | pos_ready;
	assign accept     = tick.valid & tick.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q    <= '0;
			seen_q    <= 1'b0;
			playing_q <= 1'b0;
		end else if (accept) begin
			if (same) begin
				if (seen_q && playing_q) begin
					playing_q <= 1'b0;
				end else begin
					seen_q <= 1'b1;
				end
			end else begin
				seen_q    <= 1'b0;
				last_q    <= clamped;
				playing_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= play_next;
		end else if (pos_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_s1 <= clamped;
		end
	end

	assign pos_valid = valid_s1;
	assign pos       = pos_s1;

endmodule

>>> rtl/mtc_qf_split.sv
// Splits a frame position into frames, seconds, minutes and hours over four stages.
module mtc_qf_split (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pos_valid,
	input  logic [mtc_qf_pkg::POS_W-1:0]   pos,
	output logic                           pos_ready,
	output logic                           tc_valid,
	output mtc_qf_pkg::mtc_time_t          tc,
	input  logic                           tc_ready
);
	import mtc_qf_pkg::*;

	// stage valids, index 2..5
	logic [5:2] valid_q;
	logic [5:2] rdy;

	logic [POS_W-1:0] n_s2;
	logic [26:0]      q1_s2;
	logic [4:0]       frames_s3, frames_s4, frames_s5;
	logic [26:0]      q1_s3;
	logic [20:0]      q2_s3, q2_s4;
	logic [5:0]       sec_s4, sec_s5;
	logic [14:0]      q3_s4, q3_s5;
	logic [5:0]       min_s5;
	logic [9:0]       q4_s5;

	logic [62:0] p1;
	logic [54:0] p2;
	logic [42:0] p3;
	logic [30:0] p4;
	logic [30:0] r_frames;
	logic [26:0] r_sec;
	logic [20:0] r_min;
	logic [14:0] r_hour;

	// a stage moves on when it is empty or the next one moves
	assign rdy[5]    = ~valid_q[5] | tc_ready;
	assign rdy[4]    = ~valid_q[4] | rdy[5];
	assign rdy[3]    = ~valid_q[3] | rdy[4];
	assign rdy[2]    = ~valid_q[2] | rdy[3];
	assign pos_ready = rdy[2];

	assign p1       = 63'(pos) * 63'(RCP_FPS);
	assign p2       = 55'(q1_s2) * 55'(RCP_SEC);
	assign p3       = 43'(q2_s3) * 43'(RCP_MIN);
	assign p4       = 31'(q3_s4) * 31'(RCP_HOUR);

	assign r_frames = n_s2 - 31'(q1_s2) * 31'(FPS);
	assign r_sec    = q1_s3 - 27'(q2_s3) * 27'(SIXTY);
	assign r_min    = q2_s4 - 21'(q3_s4) * 21'(SIXTY);
	assign r_hour   = q3_s5 - 15'(q4_s5) * 15'(HOUR_WRAP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (rdy[2]) valid_q[2] <= pos_valid;
			if (rdy[3]) valid_q[3] <= valid_q[2];
			if (rdy[4]) valid_q[4] <= valid_q[3];
			if (rdy[5]) valid_q[5] <= valid_q[4];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			n_s2  <= pos;
			q1_s2 <= p1[62:36];
		end
		if (rdy[3]) begin
			frames_s3 <= r_frames[4:0];
			q1_s3     <= q1_s2;
			q2_s3     <= p2[53:33];
		end
		if (rdy[4]) begin
			frames_s4 <= frames_s3;
			sec_s4    <= r_sec[5:0];
			q2_s4     <= q2_s3;
			q3_s4     <= p3[41:27];
		end
		if (rdy[5]) begin
			frames_s5 <= frames_s4;
			sec_s5    <= sec_s4;
			min_s5    <= r_min[5:0];
			q3_s5     <= q3_s4;
			q4_s5     <= p4[29:20];
		end
	end

	assign tc_valid   = valid_q[5];
	assign tc.frames  = frames_s5;
	assign tc.seconds = sec_s5;
	assign tc.minutes = min_s5;
	assign tc.hours   = r_hour[4:0];

endmodule

>>> rtl/mtc_qf_serial.sv
// Output register that sends one time value as eight quarter-frame words.
module mtc_qf_serial (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   tc_valid,
	input  mtc_qf_pkg::mtc_time_t  tc,
	output logic                   tc_ready,
	mtc_qf_if.source               msg
);
	import mtc_qf_pkg::*;

	mtc_time_t  parts_q;
	logic [2:0] piece_q;
	logic       busy_q;
	logic [3:0] nib;
	logic       last;

	assign last     = (piece_q == PC_HOUR_HI);
	assign tc_ready = ~busy_q | (msg.ready & last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			piece_q <= PC_FRAME_LO;
		end else if (tc_ready) begin
			busy_q  <= tc_valid;
			piece_q <= PC_FRAME_LO;
		end else if (msg.ready) begin
			piece_q <= piece_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (tc_ready && tc_valid) begin
			parts_q <= tc;
		end
	end

	always_comb begin
		unique case (piece_q)
			PC_FRAME_LO: nib = parts_q.frames[3:0];
			PC_FRAME_HI: nib = 4'(parts_q.frames[4]);
			PC_SEC_LO:   nib = parts_q.seconds[3:0];
			PC_SEC_HI:   nib = 4'(parts_q.seconds[5:4]);
			PC_MIN_LO:   nib = parts_q.minutes[3:0];
			PC_MIN_HI:   nib = 4'(parts_q.minutes[5:4]);
			PC_HOUR_LO:  nib = parts_q.hours[3:0];
			PC_HOUR_HI:  nib = QF_RATE_30 | 4'(parts_q.hours[4]);
			default:     nib = QF_NIBBLE;
		endcase
	end

	assign msg.valid       = busy_q;
	assign msg.status_byte = QF_STATUS;
	assign msg.data_byte   = {piece_q, nib};
	assign msg.last_piece  = last;

endmodule

>>> rtl/mtc_quarter_frame_generator.sv
// Top level of the MIDI Time Code quarter-frame generator, 30 fps.
//
// Each word on the tick channel is one poll of the player's frame position; a
// negative position counts as zero. A position that differs from the last one
// starts or keeps playback and is recorded; the same position on three ticks in
// a row stops it. While playing, every tick produces eight quarter-frame words
// on the msg channel (status 0xF1, pieces 0 to 7 in order, last_piece high on
// piece 7, which carries rate code 3 and hour bit 4); hours wrap modulo 31.
// A tick is taken in any cycle in which the first stage has room. A playing
// tick occupies the single output register until its eight words are out, one
// word per cycle when msg is not held. From acceptance the play-state register
// loads, then four reciprocal multiply stages split the time and the output
// register follows and presents the first word. Back-pressure on msg stalls
// the stages and then tick.
module mtc_quarter_frame_generator (
	input  logic      clk,
	input  logic      arst_n,
	mtc_pos_if.sink   tick,
	mtc_qf_if.source  msg
);
	import mtc_qf_pkg::*;

	logic             pos_valid;
	logic             pos_ready;
	logic [POS_W-1:0] pos;
	logic             tc_valid;
	logic             tc_ready;
	mtc_time_t        tc;

	// update play state and forward the position when playing
	mtc_qf_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick),
		.pos_valid (pos_valid),
		.pos       (pos),
		.pos_ready (pos_ready)
	);

	// split into frames, seconds, minutes and hours
	mtc_qf_split u_split (
		.clk       (clk),
		.arst_n    (arst_n),
		.pos_valid (pos_valid),
		.pos       (pos),
		.pos_ready (pos_ready),
		.tc_valid  (tc_valid),
		.tc        (tc),
		.tc_ready  (tc_ready)
	);

	// emit the eight quarter-frame words
	mtc_qf_serial u_serial (
		.clk      (clk),
		.arst_n   (arst_n),
		.tc_valid (tc_valid),
		.tc       (tc),
		.tc_ready (tc_ready),
		.msg      (msg)
	);

endmodule
